// ----- rtl/bb3_pkg.sv -----
package bb3_pkg;

  // sample and arithmetic widths
  localparam int ElevW      = 24;  // elevation, signed, 8 fraction bits
  localparam int SideW      = 7;   // grid_side register
  localparam int ColW       = 26;  // sum of one window column
  localparam int SumW       = 28;  // sum of the whole 3x3 window
  localparam int MagW       = 27;  // rounded magnitude before the divide
  localparam int QuotW      = 24;  // quotient by nine
  localparam int RecipShift = 30;

  // floor(2^30 / 9)
  localparam logic [MagW-1:0] RecipMul = 27'd119304647;
  localparam logic [3:0]      Nine     = 4'd9;

  // input command codes
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_t;

  // one result item on its way to the output
  typedef struct packed {
    logic signed [ElevW-1:0] value;
    logic                    border;
    logic                    last;
  } res_t;

endpackage

// ----- rtl/box_blur_3x3_grid_unit.sv -----
// Streaming 3x3 box filter over a square grid of signed elevations (8 fraction
// bits) sent in row-major order. Interior samples come out as the rounded mean
// of their neighborhood, border samples unchanged, in the same order and
// grid_side+1 samples behind the input; drain commands flush the pending tail
// after the last sample of a grid. One item is taken per clock while in_stall
// is low. The two previous rows live in one row RAM (upper and lower row per
// column), read on the transfer and written back in the next cycle with
// forwarding; results pass stage 1, stage 2 and the divide-by-nine pipeline
// into the output queue; in_stall rises only once 16 results are outstanding,
// so the input keeps full rate whenever the output is drained. Writing
// grid_side restarts the stream; the row RAM needs no clearing after reset.
module box_blur_3x3_grid_unit #(
  parameter int GRID_SIDE_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bb3_pkg::SideW-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic signed [bb3_pkg::ElevW-1:0]   elevation_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bb3_pkg::ElevW-1:0]   elevation_out,
  output logic                               is_border,
  output logic                               last_of_grid
);
  import bb3_pkg::*;

  localparam int AW        = $clog2(GRID_SIDE_MAX);
  localparam int PW        = $clog2(GRID_SIDE_MAX + 2);
  localparam int SideReset = (GRID_SIDE_MAX < 64) ? GRID_SIDE_MAX : 64;
  localparam int FifoDepth = 16;
  localparam int FifoAW    = $clog2(FifoDepth);
  localparam int UsedW     = $clog2(FifoDepth + 1);
  localparam int WordW     = 2 * ElevW;

  // grid geometry
  logic [AW-1:0]          side_last;
  logic [PW-1:0]          pend_full;
  logic [31:0]            cfg_wide;
  logic [31:0]            cfg_side;

  // stream position
  logic [AW-1:0]          in_row, in_col, out_r, out_c;
  logic [PW-1:0]          pend;

  // accept decode
  logic                   accept, is_drain, at_start, emit, go, pos_border, pos_last;
  logic [AW-1:0]          rd_addr;

  // row RAM and stage 1
  logic [WordW-1:0]       ram_rdata, rd_word, wr_word;
  logic signed [ElevW-1:0] rd_upper, rd_lower;
  logic                   wr_en;
  logic                   s1_valid, s1_drain, s1_emit, s1_lower_sel, s1_border, s1_last;
  logic                   s1_fwd;
  logic [WordW-1:0]       s1_fwd_data;
  logic [AW-1:0]          s1_addr;
  logic signed [ElevW-1:0] s1_x;

  // window state
  logic signed [ElevW-1:0] w12;
  logic signed [ColW-1:0]  cs0, cs1, cs2, col_sum;

  // stage 2
  logic                   s2_valid;
  res_t                   s2_meta;

  // mean pipeline and output queue
  logic                   m_valid;
  res_t                   m_res;
  res_t                   fifo_mem [FifoDepth];
  logic [FifoAW-1:0]      wr_ptr, rd_ptr;
  logic [UsedW-1:0]       fifo_count, used;
  logic                   pop;

  // clamp the written side to the supported range
  always_comb begin
    cfg_wide = 32'(cfg_wdata);
    if (cfg_wide < 32'd3) begin
      cfg_side = 32'd3;
    end else if (cfg_wide > 32'(GRID_SIDE_MAX)) begin
      cfg_side = 32'(GRID_SIDE_MAX);
    end else begin
      cfg_side = cfg_wide;
    end
  end

  // accept decode
  assign in_stall   = (used == UsedW'(FifoDepth));
  assign accept     = in_valid && !in_stall;
  assign is_drain   = (cmd_t'(command) == CMD_DRAIN);
  assign at_start   = (in_row == '0) && (in_col == '0);
  assign emit       = is_drain ? (at_start && (pend != '0)) : (pend == pend_full);
  assign go         = accept && (!is_drain || emit);
  assign pos_border = (out_r == '0) || (out_r == side_last) ||
                      (out_c == '0) || (out_c == side_last);
  assign pos_last   = (out_r == side_last) && (out_c == side_last);
  assign rd_addr    = is_drain ? out_c : in_col;

  // position counters and geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      side_last <= AW'(SideReset - 1);
      pend_full <= PW'(SideReset + 1);
      in_row    <= '0;
      in_col    <= '0;
      out_r     <= '0;
      out_c     <= '0;
      pend      <= '0;
    end else if (cfg_we) begin
      side_last <= AW'(cfg_side - 32'd1);
      pend_full <= PW'(cfg_side + 32'd1);
      in_row    <= '0;
      in_col    <= '0;
      out_r     <= '0;
      out_c     <= '0;
      pend      <= '0;
    end else if (accept) begin
      if (!is_drain) begin
        if (in_col == side_last) begin
          in_col <= '0;
          in_row <= (in_row == side_last) ? '0 : in_row + AW'(1);
        end else begin
          in_col <= in_col + AW'(1);
        end
        if (!emit) begin
          pend <= pend + PW'(1);
        end
      end else if (emit) begin
        pend <= pend - PW'(1);
      end
      if (emit) begin
        if (out_c == side_last) begin
          out_c <= '0;
          out_r <= (out_r == side_last) ? '0 : out_r + AW'(1);
        end else begin
          out_c <= out_c + AW'(1);
        end
      end
    end
  end

  // row RAM: {upper, lower} per column
  bb3_ram #(
    .Width (WordW),
    .Depth (GRID_SIDE_MAX)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_word),
    .re    (go),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // stage 1 read data with forwarding of a same-cycle write
  assign rd_word  = s1_fwd ? s1_fwd_data : ram_rdata;
  assign rd_upper = $signed(rd_word[WordW-1:ElevW]);
  assign rd_lower = $signed(rd_word[ElevW-1:0]);
  assign wr_en    = s1_valid && !s1_drain;
  assign wr_word  = {rd_lower, s1_x};
  assign col_sum  = ColW'(rd_upper) + ColW'(rd_lower) + ColW'(s1_x);

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= go;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    s1_drain     <= is_drain;
    s1_emit      <= emit;
    s1_lower_sel <= (out_r == side_last);
    s1_border    <= is_drain || pos_border;
    s1_last      <= pos_last;
    s1_addr      <= rd_addr;
    s1_x         <= elevation_in;
    s1_fwd       <= wr_en && (s1_addr == rd_addr);
    s1_fwd_data  <= wr_word;
  end

  // window shift on each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      w12 <= '0;
      cs0 <= '0;
      cs1 <= '0;
      cs2 <= '0;
    end else if (wr_en) begin
      w12 <= rd_lower;
      cs0 <= cs1;
      cs1 <= cs2;
      cs2 <= col_sum;
    end
  end

  // stage 2: results only
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_meta.border <= s1_border;
    s2_meta.last   <= s1_last;
    if (s1_drain) begin
      s2_meta.value <= s1_lower_sel ? rd_lower : rd_upper;
    end else begin
      s2_meta.value <= w12;
    end
  end

  // divide by nine
  bb3_mean9 u_mean (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_meta   (s2_meta),
    .cs0       (cs0),
    .cs1       (cs1),
    .cs2       (cs2),
    .out_valid (m_valid),
    .out_res   (m_res)
  );

  // output queue
  assign pop           = out_valid && !out_stall;
  assign out_valid     = (fifo_count != '0);
  assign elevation_out = fifo_mem[rd_ptr].value;
  assign is_border     = fifo_mem[rd_ptr].border;
  assign last_of_grid  = fifo_mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (m_valid) begin
      fifo_mem[wr_ptr] <= m_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      used       <= '0;
    end else begin
      if (m_valid) begin
        wr_ptr <= wr_ptr + FifoAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FifoAW'(1);
      end
      case ({m_valid, pop})
        2'b10:   fifo_count <= fifo_count + UsedW'(1);
        2'b01:   fifo_count <= fifo_count - UsedW'(1);
        default: fifo_count <= fifo_count;
      endcase
      // results promised but not yet transferred out
      case ({go && emit, pop})
        2'b10:   used <= used + UsedW'(1);
        2'b01:   used <= used - UsedW'(1);
        default: used <= used;
      endcase
    end
  end

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UsedW'(FifoDepth))
    else $error("outstanding result count above queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= used)
    else $error("queue holds more results than were promised");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= pend_full)
    else $error("pending count above side plus one");

  a_drain_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_drain) |-> s1_emit)
    else $error("non-emitting drain entered the pipeline");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (used != '0))
    else $error("credits lost while stalled");

endmodule

// ----- rtl/bb3_ram.sv -----
module bb3_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bb3_mean9.sv -----
module bb3_mean9 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  bb3_pkg::res_t                     in_meta,
  input  logic signed [bb3_pkg::ColW-1:0]   cs0,
  input  logic signed [bb3_pkg::ColW-1:0]   cs1,
  input  logic signed [bb3_pkg::ColW-1:0]   cs2,
  output logic                              out_valid,
  output bb3_pkg::res_t                     out_res
);
  import bb3_pkg::*;

  localparam int ProdW = 2 * MagW;

  // stage valids and carried metadata
  logic [3:0]               vld;
  res_t                     meta [4];

  logic signed [SumW-1:0]   sum;
  logic                     neg2, neg3, neg4;
  logic [MagW-1:0]          mag_r, mag3;
  logic [QuotW-1:0]         q3, q4;
  logic                     inc4;

  logic [SumW-1:0]          rnd;
  logic [ProdW-1:0]         prod;
  logic [SumW-1:0]          nine_q;
  logic [SumW-1:0]          rem;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  // add the three column sums
  always_ff @(posedge clk) begin
    sum     <= SumW'(cs0) + SumW'(cs1) + SumW'(cs2);
    meta[0] <= in_meta;
  end

  // magnitude plus four: floor((|s| + 4) / 9) rounds half away from zero
  always_comb begin
    if (sum[SumW-1]) begin
      rnd = ~sum + SumW'(5);
    end else begin
      rnd = sum + SumW'(4);
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= rnd[MagW-1:0];
    neg2    <= sum[SumW-1];
    meta[1] <= meta[0];
  end

  // reciprocal multiply, quotient is exact or one short
  assign prod = ProdW'(mag_r) * ProdW'(RecipMul);

  always_ff @(posedge clk) begin
    q3      <= prod[RecipShift+QuotW-1:RecipShift];
    mag3    <= mag_r;
    neg3    <= neg2;
    meta[2] <= meta[1];
  end

  // remainder check for the one-short case
  assign nine_q = (SumW'(q3) << 3) + SumW'(q3);
  assign rem    = SumW'(mag3) - nine_q;

  always_ff @(posedge clk) begin
    q4      <= q3;
    inc4    <= (rem >= SumW'(Nine));
    neg4    <= neg3;
    meta[3] <= meta[2];
  end

  // correct, restore sign, pick border pass-through
  always_ff @(posedge clk) begin
    out_res.border <= meta[3].border;
    out_res.last   <= meta[3].last;
    if (meta[3].border) begin
      out_res.value <= meta[3].value;
    end else if (neg4) begin
      out_res.value <= $signed(~q4 + QuotW'(!inc4));
    end else begin
      out_res.value <= $signed(q4 + QuotW'(inc4));
    end
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import bb3_pkg::*;

  localparam int GridMax    = 64;
  localparam int StimTarget = 450;
  localparam int SettleCyc  = 20;
  localparam int HoldCyc    = 120;
  localparam int CycleLimit = 400000;
  localparam int FirstSides [8] = '{3, 127, 5, 1, 2, 4, 65, 8};
  localparam logic signed [ElevW-1:0] ElevMax = 24'sh7fffff;
  localparam logic signed [ElevW-1:0] ElevMin = 24'sh800000;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [SideW-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  cmd_t                    command;
  logic signed [ElevW-1:0] elevation_in;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [ElevW-1:0] elevation_out;
  logic                    is_border;
  logic                    last_of_grid;

  box_blur_3x3_grid_unit #(
    .GRID_SIDE_MAX(GridMax)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .elevation_in (elevation_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .elevation_out(elevation_out),
    .is_border    (is_border),
    .last_of_grid (last_of_grid)
  );

  // filter state as the predictor sees it
  logic [SideW-1:0]        side_reg;
  logic signed [ElevW-1:0] upper_rows [GridMax];
  logic signed [ElevW-1:0] lower_rows [GridMax];
  logic signed [ElevW-1:0] win [3][3];
  int unsigned             next_row;
  int unsigned             next_col;
  int unsigned             next_out;
  res_t                    blurred_due [$];

  // run bookkeeping
  int stim_count;
  int result_count;
  int mismatch_count;
  int side_writes;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_ask;
  bit hold_done;
  bit pause_done;

  // directed stimulus rows
  typedef struct {
    cmd_t                    cmd;
    logic signed [ElevW-1:0] elev;
    bit                      typed;   // expectation written in the row
    bit                      emits;
    res_t                    res;
  } step_t;
  step_t steps [$];

  function automatic void add_item(input cmd_t c, input logic signed [ElevW-1:0] v,
                                   input bit typed, input bit emits,
                                   input logic signed [ElevW-1:0] ev = '0,
                                   input bit eb = 1'b0, input bit el = 1'b0);
    step_t s;
    s.cmd        = c;
    s.elev       = v;
    s.typed      = typed;
    s.emits      = emits;
    s.res.value  = ev;
    s.res.border = eb;
    s.res.last   = el;
    steps.push_back(s);
  endfunction

  // one input item through the filter; returns 1 when a result leaves
  function automatic bit blur_predict(input cmd_t c, input logic signed [ElevW-1:0] x,
                                      output res_t r);
    int unsigned n, nn, lin, pend, pr, pc;
    longint      total, q;
    bit          on_rim;
    r = '0;
    n = (side_reg < 3) ? 3 : ((side_reg > GridMax) ? GridMax : side_reg);
    nn = n * n;
    if (next_row >= n || next_col >= n || next_out >= nn) begin
      next_row = 0;
      next_col = 0;
      next_out = 0;
    end
    lin  = next_row * n + next_col;
    pend = (lin + nn - next_out) % nn;
    if (c == CMD_DRAIN) begin
      // only after a whole grid and with something pending
      if (pend == 0 || lin != 0) return 1'b0;
      pr       = next_out / n;
      pc       = next_out % n;
      r.value  = (pr == n - 1) ? lower_rows[pc] : upper_rows[pc];
      r.border = 1'b1;
    end else begin
      // shift the window and bring in the new column
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = upper_rows[next_col];
      win[1][2] = lower_rows[next_col];
      win[2][2] = x;
      upper_rows[next_col] = lower_rows[next_col];
      lower_rows[next_col] = x;
      next_col++;
      if (next_col >= n) begin
        next_col = 0;
        next_row = (next_row + 1 >= n) ? 0 : next_row + 1;
      end
      if (pend < n + 1) return 1'b0;
      pr       = next_out / n;
      pc       = next_out % n;
      on_rim   = !(pr >= 1 && pr <= n - 2 && pc >= 1 && pc <= n - 2);
      r.border = on_rim;
      if (on_rim) begin
        r.value = win[1][1];
      end else begin
        // mean of nine, rounded half away from zero
        total = 0;
        for (int i = 0; i < 9; i++) total += longint'(win[i / 3][i % 3]);
        q       = ((total < 0 ? -total : total) * 2 + 9) / 18;
        r.value = ElevW'((total < 0) ? -q : q);
      end
    end
    r.last   = (next_out == nn - 1);
    next_out = (next_out + 1 >= nn) ? 0 : next_out + 1;
    return 1'b1;
  endfunction

  function automatic logic signed [ElevW-1:0] rand_elev();
    case ($urandom_range(0, 7))
      0:       return ElevMax;
      1:       return ElevMin;
      2, 3:    return ElevW'(int'($urandom_range(0, 4000)) - 2000);
      default: return ElevW'($urandom);
    endcase
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_item(input cmd_t c, input logic signed [ElevW-1:0] v,
                           output bit got, output res_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= c;
    elevation_in <= v;
    do @(posedge clk); while (in_stall);
    got = blur_predict(c, v, r);
  endtask

  task automatic feed(input cmd_t c, input logic signed [ElevW-1:0] v);
    bit   got;
    res_t r;
    send_item(c, v, got, r);
    if (got) blurred_due.push_back(r);
    if (got || c == CMD_SAMPLE) stim_count++;
    // idle pattern follows progress through the random part
    if (stim_count < 150) begin
      send_idle_pct  = 10;
      recv_stall_pct = 79;
    end else if (stim_count < 300) begin
      send_idle_pct  = 79;
      recv_stall_pct = 10;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endtask

  // grid side write, only once the unit has gone quiet
  task automatic set_side(input logic [SideW-1:0] v);
    in_valid <= 1'b0;
    while (blurred_due.size() != 0) @(posedge clk);
    // items without a result may still be in the pipeline
    repeat (SettleCyc) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    side_reg = v;
    next_row = 0;
    next_col = 0;
    next_out = 0;
    side_writes++;
  endtask

  task automatic run_segment(input logic [SideW-1:0] side_val);
    int unsigned n, grids, tail;
    set_side(side_val);
    n = (side_val < 3) ? 3 : ((side_val > GridMax) ? GridMax : side_val);
    if (n > 8) begin
      // large side: part of one grid, just past the point where results start
      tail = n + 1 + $urandom_range(5, 30);
      for (int i = 0; i < tail; i++) begin
        if ($urandom_range(0, 19) == 0) feed(CMD_DRAIN, rand_elev());
        feed(CMD_SAMPLE, rand_elev());
      end
    end else begin
      grids = $urandom_range(1, 3);
      if (stim_count >= 300 && !hold_done && n >= 4) begin
        // long receiver hold while samples keep coming, so the unit fills up
        grids     = 3;
        hold_done = 1'b1;
        hold_ask  = 1'b1;
      end
      for (int g = 0; g < grids; g++) begin
        for (int i = 0; i < n * n; i++) begin
          if (stim_count >= 150 && !pause_done && g == 0 && i == n * n / 2) begin
            // sender waits mid-grid until every result is out
            pause_done = 1'b1;
            in_valid <= 1'b0;
            do @(posedge clk); while (blurred_due.size() != 0);
          end
          if ($urandom_range(0, 19) == 0) feed(CMD_DRAIN, rand_elev());
          feed(CMD_SAMPLE, rand_elev());
        end
      end
      // mostly flush the tail, sometimes short of it or with extra drains
      tail = ($urandom_range(0, 3) != 0) ? n + 1 : $urandom_range(0, n + 3);
      for (int i = 0; i < tail; i++) feed(CMD_DRAIN, rand_elev());
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: check each transfer, drive the stall
  initial begin
    int   hold_left;
    res_t want;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        result_count++;
        if (blurred_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: value %0d border %0b last %0b",
                     elevation_out, is_border, last_of_grid);
          mismatch_count++;
        end else begin
          want = blurred_due.pop_front();
          if (elevation_out !== want.value || is_border !== want.border ||
              last_of_grid !== want.last) begin
            if (mismatch_count < 10)
              $display("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       result_count, $signed(want.value), want.border, want.last,
                       elevation_out, is_border, last_of_grid);
            mismatch_count++;
          end
        end
      end
      // a long hold when asked, random stalls otherwise
      if (hold_ask) begin
        hold_left = HoldCyc;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // stimulus
  initial begin
    bit   got;
    res_t r;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    command      <= CMD_SAMPLE;
    elevation_in <= '0;
    side_reg = 7'd64;
    for (int i = 0; i < GridMax; i++) begin
      upper_rows[i] = '0;
      lower_rows[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    next_row       = 0;
    next_col       = 0;
    next_out       = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 79;

    // two 3x3 grids back to back: all minimum, then maximum with a -1 centre
    add_item(CMD_DRAIN, '0, 1, 0);                                  // nothing pending
    repeat (4) add_item(CMD_SAMPLE, ElevMin, 1, 0);
    repeat (4) add_item(CMD_SAMPLE, ElevMin, 1, 1, ElevMin, 1, 0);
    add_item(CMD_SAMPLE, ElevMin, 1, 1, ElevMin, 0, 0);             // mean of nine minimums
    repeat (2) add_item(CMD_SAMPLE, ElevMax, 1, 1, ElevMin, 1, 0);
    add_item(CMD_DRAIN, '0, 1, 0);                                  // drain mid-grid, ignored
    add_item(CMD_SAMPLE, ElevMax, 1, 1, ElevMin, 1, 0);
    add_item(CMD_SAMPLE, ElevMax, 1, 1, ElevMin, 1, 1);             // end of first grid
    add_item(CMD_SAMPLE, -24'sd1, 1, 1, ElevMax, 1, 0);
    repeat (3) add_item(CMD_SAMPLE, ElevMax, 1, 1, ElevMax, 1, 0);
    add_item(CMD_SAMPLE, ElevMax, 0, 0);                            // rounded mean
    repeat (3) add_item(CMD_DRAIN, '0, 1, 1, ElevMax, 1, 0);
    add_item(CMD_DRAIN, '0, 1, 1, ElevMax, 1, 1);
    add_item(CMD_DRAIN, '0, 1, 0);                                  // tail already flushed

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, side below range acts as three
    set_side('0);
    foreach (steps[i]) begin
      send_item(steps[i].cmd, steps[i].elev, got, r);
      if (steps[i].typed) begin
        if (steps[i].emits) blurred_due.push_back(steps[i].res);
      end else if (got) begin
        blurred_due.push_back(r);
      end
    end

    // random part, kept going until the hold and the pause have both happened
    foreach (FirstSides[k]) run_segment(SideW'(FirstSides[k]));
    while (stim_count < StimTarget || !hold_done || !pause_done) begin
      case ($urandom_range(0, 9))
        0:       run_segment(SideW'($urandom_range(0, 2)));
        1:       run_segment(SideW'($urandom_range(9, 127)));
        default: run_segment(SideW'($urandom_range(3, 8)));
      endcase
    end

    in_valid <= 1'b0;
    while (blurred_due.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);

    $display("%0d grid side writes, %0d samples and drains, %0d results compared",
             side_writes, stim_count, result_count);
    $display("%0d result mismatches", mismatch_count);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- box_blur_3x3_grid_unit.f -----
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_mean9.sv
rtl/box_blur_3x3_grid_unit.sv
verif/tb_top.sv
